[rtl/core/bgpopen_pkg.sv]
// Types and constants shared by the BGP OPEN message parser.
package bgpopen_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;
  localparam logic [1:0] ST_CAPLEN = 2'd3;

  localparam logic [8:0]  HDR_BYTES    = 9'd10;
  localparam logic [8:0]  POS_MAX      = 9'd511;
  localparam logic [8:0]  POS_AS_END   = 9'd5;
  localparam logic [8:0]  POS_ID_END   = 9'd9;
  localparam logic [7:0]  PARAM_CAPS   = 8'd2;
  localparam logic [7:0]  CAP_AS4      = 8'd65;
  localparam logic [7:0]  CAP_MP       = 8'd1;
  localparam logic [7:0]  CAP_MP_LEN   = 8'd4;
  localparam logic [7:0]  SAFI_UNICAST = 8'd1;
  localparam logic [15:0] AFI_IPV4     = 16'd1;
  localparam logic [15:0] AFI_IPV6     = 16'd2;

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_PTYPE  = 8'b0000_0010,
    PH_PLEN   = 8'b0000_0100,
    PH_PSKIP  = 8'b0000_1000,
    PH_CCODE  = 8'b0001_0000,
    PH_CLEN   = 8'b0010_0000,
    PH_CVAL   = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  version;
    logic [15:0] my_as_number;
    logic [15:0] hold_seconds;
    logic [31:0] router_id;
    logic        as4_seen;
    logic [31:0] as4_value;
    logic        mp_ipv4_seen;
    logic        mp_ipv6_seen;
  } result_item_t;

  typedef struct packed {
    logic [8:0]  pos;
    logic [8:0]  area_end;
    phase_t      phase;
    logic [7:0]  param_kind;
    logic [7:0]  param_rem;
    logic [7:0]  cap_code;
    logic [7:0]  cap_rem;
    logic [31:0] value_shift;
    logic [1:0]  error_code;
    logic [39:0] header_fields;
    logic [31:0] router_id;
    logic [31:0] as4;
    logic [2:0]  cap_flags;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    pos: 9'd0, area_end: 9'd0, phase: PH_HEADER, param_kind: 8'd0,
    param_rem: 8'd0, cap_code: 8'd0, cap_rem: 8'd0, value_shift: 32'd0,
    error_code: 2'd0, header_fields: 40'd0, router_id: 32'd0, as4: 32'd0,
    cap_flags: 3'd0
  };

endpackage

[rtl/core/bgpopen_step.sv]
// Per-byte next-state and result logic of the OPEN message parser.
module bgpopen_step (
  input  bgpopen_pkg::parse_state_t state,
  input  bgpopen_pkg::byte_item_t   item,
  output bgpopen_pkg::parse_state_t state_next,
  output bgpopen_pkg::result_item_t result
);

  logic [9:0]  pos10;
  logic [9:0]  end10;
  logic [9:0]  end_next10;
  logic [9:0]  area_left;
  logic [7:0]  b;
  logic [7:0]  rem_dec;
  logic [7:0]  cap_dec;
  logic [31:0] vs_new;
  bgpopen_pkg::phase_t param_done_phase;

  assign b          = item.data_byte;
  assign pos10      = {1'b0, state.pos};
  assign end10      = {1'b0, state.area_end};
  assign end_next10 = {1'b0, state_next.area_end};
  assign area_left  = end10 - pos10;
  assign rem_dec    = state.param_rem - 8'd1;
  assign cap_dec    = state.cap_rem - 8'd1;
  assign vs_new     = {state.value_shift[23:0], b};
  assign param_done_phase = (pos10 + 10'd1 >= end10) ? bgpopen_pkg::PH_DONE
                                                     : bgpopen_pkg::PH_PTYPE;

  always_comb begin
    state_next = state;
    state_next.pos = (state.pos == bgpopen_pkg::POS_MAX) ? state.pos : state.pos + 9'd1;
    case (state.phase)
      bgpopen_pkg::PH_HEADER: begin
        if (state.pos < bgpopen_pkg::POS_AS_END) begin
          state_next.header_fields = {state.header_fields[31:0], b};
        end else if (state.pos < bgpopen_pkg::POS_ID_END) begin
          state_next.router_id = {state.router_id[23:0], b};
        end else begin
          state_next.area_end = bgpopen_pkg::HDR_BYTES + {1'b0, b};
          state_next.phase = (b == 8'd0) ? bgpopen_pkg::PH_DONE : bgpopen_pkg::PH_PTYPE;
        end
      end
      bgpopen_pkg::PH_PTYPE: begin
        if (area_left < 10'd2) begin
          state_next.error_code = bgpopen_pkg::ST_TRUNC;
          state_next.phase = bgpopen_pkg::PH_DONE;
        end else begin
          state_next.param_kind = b;
          state_next.phase = bgpopen_pkg::PH_PLEN;
        end
      end
      bgpopen_pkg::PH_PLEN: begin
        if ({2'b00, b} > area_left - 10'd1) begin
          state_next.error_code = bgpopen_pkg::ST_TRUNC;
          state_next.phase = bgpopen_pkg::PH_DONE;
        end else begin
          state_next.param_rem = b;
          if (b == 8'd0) begin
            state_next.phase = param_done_phase;
          end else if (state.param_kind == bgpopen_pkg::PARAM_CAPS) begin
            state_next.phase = bgpopen_pkg::PH_CCODE;
          end else begin
            state_next.phase = bgpopen_pkg::PH_PSKIP;
          end
        end
      end
      bgpopen_pkg::PH_PSKIP: begin
        state_next.param_rem = rem_dec;
        if (rem_dec == 8'd0) begin
          state_next.phase = param_done_phase;
        end
      end
      bgpopen_pkg::PH_CCODE: begin
        if (state.param_rem < 8'd2) begin
          state_next.error_code = bgpopen_pkg::ST_TRUNC;
          state_next.phase = bgpopen_pkg::PH_DONE;
        end else begin
          state_next.cap_code = b;
          state_next.param_rem = rem_dec;
          state_next.phase = bgpopen_pkg::PH_CLEN;
        end
      end
      bgpopen_pkg::PH_CLEN: begin
        state_next.param_rem = rem_dec;
        if (b > rem_dec) begin
          state_next.error_code = bgpopen_pkg::ST_TRUNC;
          state_next.phase = bgpopen_pkg::PH_DONE;
        end else if ((state.cap_code == bgpopen_pkg::CAP_AS4 ||
                      state.cap_code == bgpopen_pkg::CAP_MP) &&
                     b != bgpopen_pkg::CAP_MP_LEN) begin
          state_next.error_code = bgpopen_pkg::ST_CAPLEN;
          state_next.phase = bgpopen_pkg::PH_DONE;
        end else begin
          state_next.cap_rem = b;
          state_next.value_shift = 32'd0;
          if (b != 8'd0) begin
            state_next.phase = bgpopen_pkg::PH_CVAL;
          end else if (rem_dec == 8'd0) begin
            state_next.phase = param_done_phase;
          end else begin
            state_next.phase = bgpopen_pkg::PH_CCODE;
          end
        end
      end
      bgpopen_pkg::PH_CVAL: begin
        state_next.value_shift = vs_new;
        state_next.param_rem = rem_dec;
        state_next.cap_rem = cap_dec;
        if (cap_dec == 8'd0) begin
          if (state.cap_code == bgpopen_pkg::CAP_AS4) begin
            state_next.as4 = vs_new;
            state_next.cap_flags[0] = 1'b1;
          end else if (state.cap_code == bgpopen_pkg::CAP_MP &&
                       vs_new[7:0] == bgpopen_pkg::SAFI_UNICAST) begin
            if (vs_new[31:16] == bgpopen_pkg::AFI_IPV4) begin
              state_next.cap_flags[1] = 1'b1;
            end
            if (vs_new[31:16] == bgpopen_pkg::AFI_IPV6) begin
              state_next.cap_flags[2] = 1'b1;
            end
          end
          state_next.phase = (rem_dec == 8'd0) ? param_done_phase : bgpopen_pkg::PH_CCODE;
        end
      end
      default: begin
      end
    endcase
  end

  // status priority: short message, short parameter area, first TLV error
  always_comb begin
    result = '0;
    if (state.pos < bgpopen_pkg::POS_ID_END) begin
      result.status = bgpopen_pkg::ST_TRUNC;
    end else begin
      result.version      = state_next.header_fields[39:32];
      result.my_as_number = state_next.header_fields[31:16];
      result.hold_seconds = state_next.header_fields[15:0];
      result.router_id    = state_next.router_id;
      if (pos10 + 10'd1 < end_next10) begin
        result.status = bgpopen_pkg::ST_BADLEN;
      end else begin
        result.status       = state_next.error_code;
        result.as4_seen     = state_next.cap_flags[0];
        result.as4_value    = state_next.as4;
        result.mp_ipv4_seen = state_next.cap_flags[1];
        result.mp_ipv6_seen = state_next.cap_flags[2];
      end
    end
  end

endmodule

[rtl/core/bgp_open_message_parser_core.sv]
// Top level of the BGP OPEN message parser: parser state and result register.
// Throughput: one byte per cycle while no result waits, including the byte after a
// last byte if result_ready is high. A last byte's result appears in the next cycle.
// A result waiting in the result register holds off the next byte until it is taken.
// Synchronous reset returns the parser to the header phase and drops result_valid.
module bgp_open_message_parser_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_ready,
  input  bgpopen_pkg::byte_item_t   byte_item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output bgpopen_pkg::result_item_t result_item
);

  bgpopen_pkg::parse_state_t state;
  bgpopen_pkg::parse_state_t state_next;
  bgpopen_pkg::result_item_t result_next;
  logic                      accept;
  logic                      out_free;

  assign out_free   = !result_valid || result_ready;
  assign byte_ready = out_free;
  assign accept     = byte_valid && byte_ready;

  bgpopen_step u_step (
    .state      (state),
    .item       (byte_item),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgpopen_pkg::PARSE_RESET;
    end else if (accept) begin
      state <= byte_item.last ? bgpopen_pkg::PARSE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= accept && byte_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && accept && byte_item.last) begin
      result_item <= result_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && byte_item.last |=> state.pos == 9'd0 && state.phase == bgpopen_pkg::PH_HEADER)
    else $error("parser did not restart after last byte");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(accept && byte_item.last))
    else $error("result without a last byte");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    accept && !byte_item.last && state.pos != bgpopen_pkg::POS_MAX
      |=> state.pos == $past(state.pos) + 9'd1)
    else $error("byte position did not advance");

  a_as4_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.as4_seen |-> result_item.as4_value == 32'd0)
    else $error("as4 value without as4 capability");

endmodule
